// ===== sv/lpmq_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmq_pkg
// Shared types, codes and helpers of the length-prefixed message queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lpmq_pkg;

    // Byte ring size and pointer widths
    localparam int BUF_BYTES = 128;
    localparam int PTR_W     = $clog2(BUF_BYTES);
    localparam int SUM_W     = PTR_W + 2;

    // Command codes
    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;
    localparam logic [1:0] CMD_DISC = 2'd3;

    // Status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_TOO_LONG = 3'd1;
    localparam logic [2:0] STS_EMPTY    = 3'd2;
    localparam logic [2:0] STS_SEQ      = 3'd3;
    localparam logic [2:0] STS_OFFSET   = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_CAP  = 2'd0;
    localparam logic [1:0] REG_SLOT = 2'd1;

    // Reset values of the registers
    localparam logic [7:0] CAP_RST  = 8'd128;
    localparam logic [7:0] SLOT_RST = 8'd5;

    // Read address selects
    localparam logic [1:0] RD_HEAD_LO = 2'd0;
    localparam logic [1:0] RD_HEAD_HI = 2'd1;
    localparam logic [1:0] RD_PEEK    = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       latch_in;
        logic       push_data;
        logic       push_lo;
        logic       push_hi;
        logic       start_msg;
        logic       drop;
        logic [1:0] rd_sel;
        logic       hl_cap_lo;
        logic       hl_cap_hi;
        logic       peek_cap;
        logic       set_status;
        logic [2:0] status_code;
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] cmd;
        logic       open;
        logic       too_long;
        logic       empty;
        logic       need_drop;
        logic       off_bad;
    } stat_t;

    // Effective capacity, clamped into 3..BUF_BYTES
    function automatic logic [7:0] cap_eff(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c < 8'd3) r = 8'd3;
        if (32'(c) > BUF_BYTES) r = 8'(BUF_BYTES);
        return r;
    endfunction

    // Effective slot count, at least two
    function automatic logic [7:0] slots_eff(input logic [7:0] s);
        return (s < 8'd2) ? 8'd2 : s;
    endfunction

    // Reduce a sum below twice the capacity into the ring
    function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] sum,
                                                  input logic [7:0] c);
        logic [SUM_W-1:0] d;
        d = sum - SUM_W'(c);
        return (sum >= SUM_W'(c)) ? d[PTR_W-1:0] : sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/lpmq_datapath.sv =====
// ----------------------------------------------------------------------------
// lpmq_datapath
// Byte ring, pointers, slot indices and result registers of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmq_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic [1:0]           cmd,
    input  wire logic [7:0]           data_byte,
    input  wire logic [15:0]          message_length,
    input  wire logic [15:0]          read_offset,
    input  wire lpmq_pkg::ctl_t       ctl,
    output lpmq_pkg::stat_t           st,
    output logic [2:0]                status,
    output logic [7:0]                byte_out,
    output logic [15:0]               head_length,
    output logic [7:0]                dropped_count,
    output logic [7:0]                front_slot,
    output logic [7:0]                rear_slot,
    output logic [7:0]                bytes_used
);

    logic [7:0]                 cap_reg;
    logic [7:0]                 slot_reg;
    logic [lpmq_pkg::PTR_W-1:0] wp_reg;
    logic [lpmq_pkg::PTR_W-1:0] rp_reg;
    logic [7:0]                 free_reg;
    logic [7:0]                 head_reg;
    logic [7:0]                 tail_reg;
    logic                       open_reg;
    logic [15:0]                rem_reg;
    logic [15:0]                msg_len_reg;
    logic [15:0]                hl_reg;
    logic [7:0]                 hl_lo_reg;
    logic [1:0]                 cmd_reg;
    logic [7:0]                 data_reg;
    logic [15:0]                len_reg;
    logic [15:0]                off_reg;
    logic [2:0]                 status_reg;
    logic [7:0]                 bout_reg;
    logic [7:0]                 drops_reg;
    logic [7:0]                 rd_data_reg;

    logic [7:0] mem [0:lpmq_pkg::BUF_BYTES-1];

    logic [7:0]                 c_eff;
    logic [7:0]                 s_eff;
    logic                       empty;
    logic [7:0]                 tail_inc;
    logic [7:0]                 head_inc;
    logic [16:0]                len_p2;
    logic [16:0]                hl_p2;
    logic [7:0]                 used;
    logic [7:0]                 drop_n;
    logic [lpmq_pkg::PTR_W-1:0] rp_drop;
    logic [lpmq_pkg::PTR_W-1:0] rp_next1;
    logic [lpmq_pkg::PTR_W-1:0] peek_addr;
    logic [lpmq_pkg::PTR_W-1:0] wp_inc;
    logic [lpmq_pkg::PTR_W-1:0] rd_addr;
    logic                       push_en;
    logic                       do_push;
    logic [7:0]                 push_val;
    logic [15:0]                rem_dec;
    logic                       commit_now;
    logic [15:0]                commit_len;

    // Derived sizes and queue conditions
    assign c_eff    = lpmq_pkg::cap_eff(cap_reg);
    assign s_eff    = lpmq_pkg::slots_eff(slot_reg);
    assign empty    = (free_reg >= c_eff) || (head_reg == tail_reg);
    assign tail_inc = ((tail_reg + 8'd1) == s_eff) ? 8'd0 : tail_reg + 8'd1;
    assign head_inc = ((head_reg + 8'd1) == s_eff) ? 8'd0 : head_reg + 8'd1;
    assign len_p2   = 17'(len_reg) + 17'd2;
    assign hl_p2    = 17'(hl_reg) + 17'd2;
    assign used     = c_eff - free_reg;

    // Head drop: prefix plus payload, never more than is stored
    assign drop_n  = (hl_p2 > 17'(used)) ? used : hl_p2[7:0];
    assign rp_drop = lpmq_pkg::wrap_ptr(lpmq_pkg::SUM_W'(rp_reg)
                                        + lpmq_pkg::SUM_W'(drop_n), c_eff);

    // Ring addresses
    assign rp_next1  = lpmq_pkg::wrap_ptr(lpmq_pkg::SUM_W'(rp_reg)
                                          + lpmq_pkg::SUM_W'(1), c_eff);
    assign wp_inc    = lpmq_pkg::wrap_ptr(lpmq_pkg::SUM_W'(wp_reg)
                                          + lpmq_pkg::SUM_W'(1), c_eff);
    // offset is below the head length, which is below the capacity
    assign peek_addr = lpmq_pkg::wrap_ptr(lpmq_pkg::SUM_W'(rp_reg) + lpmq_pkg::SUM_W'(2)
                                          + lpmq_pkg::SUM_W'(off_reg[lpmq_pkg::PTR_W-1:0]),
                                          c_eff);

    always_comb
    begin
        unique case (ctl.rd_sel)
            lpmq_pkg::RD_HEAD_HI: rd_addr = rp_next1;
            lpmq_pkg::RD_PEEK:    rd_addr = peek_addr;
            default:              rd_addr = rp_reg;
        endcase
    end

    // Byte push
    assign push_en  = ctl.push_data || ctl.push_lo || ctl.push_hi;
    assign do_push  = push_en && (free_reg != 8'd0);
    assign push_val = ctl.push_lo ? len_reg[7:0] :
                      ctl.push_hi ? len_reg[15:8] : data_reg;
    assign rem_dec  = (rem_reg != 16'd0) ? rem_reg - 16'd1 : rem_reg;

    // Commit of a message
    assign commit_now = (ctl.push_data && (rem_dec == 16'd0))
                     || (ctl.start_msg && (len_reg == 16'd0));
    assign commit_len = ctl.start_msg ? len_reg : msg_len_reg;

    // Ring storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wp_reg] <= push_val;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Queue control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= lpmq_pkg::CAP_RST;
            slot_reg <= lpmq_pkg::SLOT_RST;
            wp_reg   <= '0;
            rp_reg   <= '0;
            free_reg <= lpmq_pkg::cap_eff(lpmq_pkg::CAP_RST);
            head_reg <= '0;
            tail_reg <= '0;
            open_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else if (cfg_write && (cfg_index == lpmq_pkg::REG_CAP
                               || cfg_index == lpmq_pkg::REG_SLOT))
        begin
            // register write empties the queue
            if (cfg_index == lpmq_pkg::REG_CAP)
            begin
                cap_reg  <= cfg_data;
                free_reg <= lpmq_pkg::cap_eff(cfg_data);
            end
            else
            begin
                slot_reg <= cfg_data;
                free_reg <= c_eff;
            end
            wp_reg   <= '0;
            rp_reg   <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            open_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg   <= wp_inc;
                free_reg <= free_reg - 8'd1;
            end
            if (ctl.drop)
            begin
                rp_reg   <= rp_drop;
                free_reg <= free_reg + drop_n;
                head_reg <= head_inc;
            end
            if (ctl.push_data)
            begin
                rem_reg <= rem_dec;
            end
            if (ctl.start_msg)
            begin
                rem_reg  <= len_reg;
                open_reg <= 1'b1;
            end
            if (commit_now)
            begin
                tail_reg <= tail_inc;
                open_reg <= 1'b0;
            end
        end
    end

    // Item latch, head length and result registers
    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            cmd_reg    <= cmd;
            data_reg   <= data_byte;
            len_reg    <= message_length;
            off_reg    <= read_offset;
            status_reg <= lpmq_pkg::STS_OK;
            bout_reg   <= '0;
            drops_reg  <= '0;
        end
        if (ctl.set_status)
        begin
            status_reg <= ctl.status_code;
        end
        // only drops made to admit a new message are counted
        if (ctl.drop && (cmd_reg == lpmq_pkg::CMD_ENQ))
        begin
            drops_reg <= drops_reg + 8'd1;
        end
        if (ctl.peek_cap)
        begin
            bout_reg <= rd_data_reg;
        end
        if (ctl.hl_cap_lo)
        begin
            hl_lo_reg <= rd_data_reg;
        end
        if (ctl.start_msg)
        begin
            msg_len_reg <= len_reg;
        end
        if (ctl.hl_cap_hi)
        begin
            hl_reg <= {rd_data_reg, hl_lo_reg};
        end
        else if (commit_now && (head_reg == tail_reg))
        begin
            // the committed message becomes the head
            hl_reg <= commit_len;
        end
    end

    // Status toward the controller
    assign st.cmd       = cmd_reg;
    assign st.open      = open_reg;
    assign st.too_long  = len_p2 > 17'(c_eff);
    assign st.empty     = empty;
    assign st.need_drop = ((len_p2 > 17'(free_reg)) || (tail_inc == head_reg)) && !empty;
    assign st.off_bad   = off_reg >= hl_reg;

    // Result fields
    assign status        = status_reg;
    assign byte_out      = bout_reg;
    assign head_length   = empty ? 16'd0 : hl_reg;
    assign dropped_count = drops_reg;
    assign front_slot    = head_reg;
    assign rear_slot     = tail_reg;
    assign bytes_used    = used;

endmodule

`default_nettype wire

// ===== sv/lpmq_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpmq_ctrl
// Command sequencer: decodes each item and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  wire lpmq_pkg::stat_t st,
    output lpmq_pkg::ctl_t       ctl
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EXEC    = 4'd1;
    localparam logic [3:0] S_DROP    = 4'd2;
    localparam logic [3:0] S_PUSH_LO = 4'd3;
    localparam logic [3:0] S_PUSH_HI = 4'd4;
    localparam logic [3:0] S_HL0     = 4'd5;
    localparam logic [3:0] S_HL1     = 4'd6;
    localparam logic [3:0] S_HL2     = 4'd7;
    localparam logic [3:0] S_PEEK0   = 4'd8;
    localparam logic [3:0] S_PEEK1   = 4'd9;
    localparam logic [3:0] S_RESP    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_RESP);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.rd_sel = lpmq_pkg::RD_HEAD_LO;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch_in = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                if (st.cmd == lpmq_pkg::CMD_BYTE)
                begin
                    if (st.open)
                    begin
                        ctl.push_data = 1'b1;
                    end
                    else
                    begin
                        ctl.set_status  = 1'b1;
                        ctl.status_code = lpmq_pkg::STS_SEQ;
                    end
                end
                else if (st.open)
                begin
                    ctl.set_status  = 1'b1;
                    ctl.status_code = lpmq_pkg::STS_SEQ;
                end
                else
                begin
                    unique case (st.cmd)
                        lpmq_pkg::CMD_ENQ:
                        begin
                            if (st.too_long)
                            begin
                                ctl.set_status  = 1'b1;
                                ctl.status_code = lpmq_pkg::STS_TOO_LONG;
                            end
                            else
                            begin
                                state_next = S_DROP;
                            end
                        end
                        lpmq_pkg::CMD_PEEK:
                        begin
                            if (st.empty)
                            begin
                                ctl.set_status  = 1'b1;
                                ctl.status_code = lpmq_pkg::STS_EMPTY;
                            end
                            else if (st.off_bad)
                            begin
                                ctl.set_status  = 1'b1;
                                ctl.status_code = lpmq_pkg::STS_OFFSET;
                            end
                            else
                            begin
                                state_next = S_PEEK0;
                            end
                        end
                        default:
                        begin
                            // discard
                            if (st.empty)
                            begin
                                ctl.set_status  = 1'b1;
                                ctl.status_code = lpmq_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                ctl.drop   = 1'b1;
                                state_next = S_HL0;
                            end
                        end
                    endcase
                end
            end
            S_DROP:
            begin
                if (st.need_drop)
                begin
                    ctl.drop   = 1'b1;
                    state_next = S_HL0;
                end
                else
                begin
                    state_next = S_PUSH_LO;
                end
            end
            S_PUSH_LO:
            begin
                ctl.push_lo = 1'b1;
                state_next  = S_PUSH_HI;
            end
            S_PUSH_HI:
            begin
                ctl.push_hi   = 1'b1;
                ctl.start_msg = 1'b1;
                state_next    = S_RESP;
            end
            // reload head length from the new head prefix
            S_HL0:
            begin
                ctl.rd_sel = lpmq_pkg::RD_HEAD_LO;
                state_next = S_HL1;
            end
            S_HL1:
            begin
                ctl.rd_sel    = lpmq_pkg::RD_HEAD_HI;
                ctl.hl_cap_lo = 1'b1;
                state_next    = S_HL2;
            end
            S_HL2:
            begin
                ctl.hl_cap_hi = 1'b1;
                state_next    = (st.cmd == lpmq_pkg::CMD_ENQ) ? S_DROP : S_RESP;
            end
            S_PEEK0:
            begin
                ctl.rd_sel = lpmq_pkg::RD_PEEK;
                state_next = S_PEEK1;
            end
            S_PEEK1:
            begin
                ctl.peek_cap = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/length_prefixed_message_queue.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_message_queue
// Queue of whole length-prefixed messages in a byte ring, dropping the
// oldest messages to admit a new one.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | input     | in_valid/in_stall  | cmd, data_byte, message_length,
//          |           |                    | read_offset
//  out     | output    | out_valid/out_stall| status, byte_out, head_length,
//          |           |                    | dropped_count, front_slot,
//          |           |                    | rear_slot, bytes_used
//  cfg     | input     | cfg_write          | cfg_index, cfg_data
//
//  One item at a time; the result is held until taken, then the next item
//  is accepted. Payload byte, refused and too-long items go from decode
//  straight to the result; peek reads one ring byte; discard and begin-enqueue
//  drop head messages, and each drop rereads the new head prefix through the
//  single ring read port. Reset (rst_n low, asynchronous) empties the queue;
//  a register write does the same. Stall on the output holds the result and the input stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_message_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] message_length,
    input  wire logic [15:0] read_offset,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [7:0]       byte_out,
    output logic [15:0]      head_length,
    output logic [7:0]       dropped_count,
    output logic [7:0]       front_slot,
    output logic [7:0]       rear_slot,
    output logic [7:0]       bytes_used
);

    lpmq_pkg::ctl_t  ctl;
    lpmq_pkg::stat_t st;

    lpmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .ctl       (ctl)
    );

    lpmq_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .data_byte      (data_byte),
        .message_length (message_length),
        .read_offset    (read_offset),
        .ctl            (ctl),
        .st             (st),
        .status         (status),
        .byte_out       (byte_out),
        .head_length    (head_length),
        .dropped_count  (dropped_count),
        .front_slot     (front_slot),
        .rear_slot      (rear_slot),
        .bytes_used     (bytes_used)
    );

endmodule

`default_nettype wire

// ===== sv/lpmq_checker.sv =====
// ----------------------------------------------------------------------------
// lpmq_checker
// Port-level checks of the message queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_write,
    input wire logic [1:0]  cfg_index,
    input wire logic [7:0]  cfg_data,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  cmd,
    input wire logic [7:0]  data_byte,
    input wire logic [15:0] message_length,
    input wire logic [15:0] read_offset,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  status,
    input wire logic [7:0]  byte_out,
    input wire logic [15:0] head_length,
    input wire logic [7:0]  dropped_count,
    input wire logic [7:0]  front_slot,
    input wire logic [7:0]  rear_slot,
    input wire logic [7:0]  bytes_used
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(byte_out))
        else $error("stalled result changed");

    // Accepted item keeps the input busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not busy after accept");

    // Status code in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= lpmq_pkg::STS_OFFSET)
        else $error("bad status code");

    // Failed commands carry no byte and no drops
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != lpmq_pkg::STS_OK |-> byte_out == 8'd0
                                                   && dropped_count == 8'd0)
        else $error("failed command reports data");

    // Occupancy never exceeds the ring
    a_used: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(bytes_used) <= lpmq_pkg::BUF_BYTES)
        else $error("occupancy beyond ring");

endmodule

bind length_prefixed_message_queue lpmq_checker u_lpmq_checker (.*);

`default_nettype wire
